// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers included by dret_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication outside reset
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/dret_pkg.sv =====
`timescale 1ns / 1ps
package dret_pkg;

    localparam int TARGET_BITS = 256;
    localparam int LIMB_W      = 32;
    localparam int SPAN_W      = 35;
    localparam int CFG_IDX_W   = 3;

    // Division chain: quotient bits settled per cell, and cell count
    localparam int CELL_QBITS  = 4;
    localparam int NUM_CELLS   = TARGET_BITS / CELL_QBITS;

    // Pipeline stages up to done: expansion, two product stages, one per
    // cell, two encode stages
    localparam int PIPE_LAT    = NUM_CELLS + 5;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TIMESPAN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT0   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT1   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT2   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT3   = 3'd5;

    // Control word handed down the division chain
    typedef struct packed {
        logic        vld;
        logic        hold;
        logic        zdiv;
        logic [31:0] prev;
    } dret_ctl_t;

endpackage

// ===== hw/rtl/dret_div_cell.sv =====
`timescale 1ns / 1ps
// One cell of the long-division chain: QBITS quotient bits per cycle, radix 2,
// handled as one restoring step per bit against a 32-bit divisor.
module dret_div_cell #(
    parameter int NUM_LIMBS = 8,
    parameter int QBITS     = dret_pkg::CELL_QBITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  dret_pkg::dret_ctl_t                   ctl_in,
    input  logic [31:0]                           div_in,
    input  logic [NUM_LIMBS*32-1:0]               num_in,
    input  logic [31:0]                           rem_in,
    output dret_pkg::dret_ctl_t                   ctl_out,
    output logic [31:0]                           div_out,
    output logic [NUM_LIMBS*32-1:0]               num_out,
    output logic [31:0]                           rem_out
);
    import dret_pkg::*;

    dret_ctl_t               ctl_reg;
    logic [31:0]             div_reg;
    logic [NUM_LIMBS*32-1:0] num_reg;
    logic [31:0]             rem_reg;
    logic [NUM_LIMBS*32-1:0] num_next;
    logic [31:0]             rem_next;

    // Shift top bits in one by one, producing quotient bits in their place
    always_comb
    begin
        logic [32:0]      r;
        logic [QBITS-1:0] top;
        logic [QBITS-1:0] q;
        r   = {1'b0, rem_in};
        top = num_in[NUM_LIMBS*32-1 -: QBITS];
        q   = '0;
        for (int b = QBITS - 1; b >= 0; b--)
        begin
            r = {r[31:0], top[b]};
            if (r >= {1'b0, div_in})
            begin
                r    = r - {1'b0, div_in};
                q[b] = 1'b1;
            end
        end
        rem_next = r[31:0];
        num_next = {num_in[NUM_LIMBS*32-QBITS-1:0], q};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else
            ctl_reg <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        div_reg <= div_in;
        num_reg <= num_next;
        rem_reg <= rem_next;
    end

    assign ctl_out = ctl_reg;
    assign div_out = div_reg;
    assign num_out = num_reg;
    assign rem_out = rem_reg;
endmodule

// ===== hw/rtl/dret_encode.sv =====
`timescale 1ns / 1ps
// Limit clamp then compact encoding (or the previous bits in hold mode), two register stages.
module dret_encode (
    input  logic                clk,
    input  logic                rst_n,
    input  dret_pkg::dret_ctl_t ctl_in,
    input  logic [255:0]        quo_in,
    input  logic [255:0]        limit,
    output logic                done,
    output logic [31:0]         bits
);
    import dret_pkg::*;

    logic         vld1_reg, vld2_reg;
    logic         hold1_reg;
    logic [31:0]  prev1_reg;
    logic [255:0] val_reg;
    logic [255:0] val_next;
    logic [31:0]  bits_reg, bits_next;

    // Clamp to limit; zero divisor means all ones
    always_comb
    begin
        logic [255:0] q;
        q = ctl_in.zdiv ? '1 : quo_in;
        val_next = (q > limit) ? limit : q;
    end

    // Byte length and 24-bit mantissa pick
    always_comb
    begin
        logic [5:0]   size;
        logic [6:0]   sz;
        logic [255:0] sh;
        logic [23:0]  mant;
        size = '0;
        for (int k = 0; k < 32; k++)
            if (val_reg[k*8 +: 8] != 8'd0)
                size = 6'(k + 1);
        if (size <= 6'd3)
        begin
            sh = val_reg << (5'(3 - size) * 8);
        end
        else
        begin
            sh = val_reg >> ({2'b0, size - 6'd3} * 8);
        end
        mant = sh[23:0];
        sz   = {1'b0, size};
        if (mant[23])
        begin
            mant = {8'd0, mant[23:8]};
            sz   = sz + 7'd1;
        end
        bits_next = hold1_reg ? prev1_reg : {1'b0, sz, mant};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= ctl_in.vld;
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        hold1_reg <= ctl_in.hold;
        prev1_reg <= ctl_in.prev;
        val_reg   <= val_next;
        bits_reg  <= bits_next;
    end

    assign done = vld2_reg;
    assign bits = bits_reg;
endmodule

// ===== hw/rtl/difficulty_retarget.sv =====
`timescale 1ns / 1ps
// Difficulty retarget. A word is taken whenever start is high and busy low;
// busy never rises, so a new word can start every cycle. done is high, with
// next_bits, once the word has passed the span clamp and expansion stage, the
// 256x35 product (partial products, then their sum), the division chain (64
// cells, each registered, four quotient bits per cell at 256 bits) and the
// limit clamp and encoding stages. The receiver cannot stall; done lasts one
// cycle per result. The user must write configuration through cfg_valid/cfg_ready
// only while idle; the block itself does not enforce it.
module difficulty_retarget (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] prev_bits,
    input  logic [31:0] last_time,
    input  logic [31:0] first_time,
    output logic        done,
    output logic [31:0] next_bits,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [dret_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0] cfg_data
);
    import dret_pkg::*;

    localparam int NL = TARGET_BITS / LIMB_W;
    localparam int NC = NUM_CELLS;

    logic [31:0]  tspan_reg;
    logic         hold_reg;
    logic [255:0] limit_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tspan_reg <= 32'd1209600;
            hold_reg  <= 1'b0;
            limit_reg <= {64'h0000_0000_FFFF_FFFF, {192{1'b1}}};
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_TIMESPAN: tspan_reg <= cfg_data[31:0];
                REG_HOLD:     hold_reg  <= cfg_data[0];
                REG_LIMIT0:   limit_reg[63:0]    <= cfg_data;
                REG_LIMIT1:   limit_reg[127:64]  <= cfg_data;
                REG_LIMIT2:   limit_reg[191:128] <= cfg_data;
                REG_LIMIT3:   limit_reg[255:192] <= cfg_data;
                default:      ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    // Stage 0: span clamp and compact expansion
    dret_ctl_t         c0_reg;
    logic [SPAN_W-1:0] span_reg;
    logic [NL*32-1:0]  exp_reg;
    logic [SPAN_W-1:0] span_next;
    logic [NL*32-1:0]  exp_next;

    always_comb
    begin
        logic signed [33:0] d;
        logic [SPAN_W-1:0]  lo, hi;
        logic [7:0]         size;
        logic [NL*32+22:0]  m;
        d  = $signed({2'b0, last_time}) - $signed({2'b0, first_time});
        lo = SPAN_W'(tspan_reg >> 2);
        hi = {1'b0, tspan_reg, 2'b0};
        if (d < 0 || SPAN_W'(d) < lo)
            span_next = lo;
        else if (SPAN_W'(d) > hi)
            span_next = hi;
        else
            span_next = SPAN_W'(d);
        size = prev_bits[31:24];
        m    = (NL*32+23)'(prev_bits[22:0]);
        if (size <= 8'd3)
            exp_next = (NL*32)'(m >> ((8'd3 - size) * 8));
        else
            exp_next = (NL*32)'(m << (11'(size - 8'd3) * 8));
    end

    // Stage 1-2: product split into 8 partial products of 32x35
    dret_ctl_t                c1_reg, c2_reg;
    logic [NL-1:0][66:0]      pp_reg;
    logic [NL*32-1:0]         prod_reg;
    logic [NL*32-1:0]         prod_next;
    logic [31:0]              ts1_reg, ts2_reg;

    always_comb
    begin
        logic [NL*32-1:0] acc;
        acc = '0;
        for (int i = 0; i < NL; i++)
            acc = acc + ((NL*32)'(pp_reg[i]) << (i*32));
        prod_next = acc;
    end

    // Control words down the front stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c0_reg <= '0;
            c1_reg <= '0;
            c2_reg <= '0;
        end
        else
        begin
            c0_reg <= '{vld: start, hold: hold_reg, zdiv: (tspan_reg == 32'd0),
                        prev: prev_bits};
            c1_reg <= c0_reg;
            c2_reg <= c1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        span_reg <= span_next;
        exp_reg  <= exp_next;
        ts1_reg  <= tspan_reg;
        for (int i = 0; i < NL; i++)
            pp_reg[i] <= 67'(exp_reg[i*32 +: 32]) * 67'(span_reg);
        ts2_reg  <= ts1_reg;
        prod_reg <= prod_next;
    end

    // Division chain: CELL_QBITS quotient bits per cell
    dret_ctl_t        ch_ctl [NC+1];
    logic [31:0]      ch_div [NC+1];
    logic [NL*32-1:0] ch_num [NC+1];
    logic [31:0]      ch_rem [NC+1];

    assign ch_ctl[0] = c2_reg;
    assign ch_div[0] = (ts2_reg == 32'd0) ? 32'd1 : ts2_reg;
    assign ch_num[0] = prod_reg;
    assign ch_rem[0] = '0;

    for (genvar g = 0; g < NC; g++)
    begin : g_cell
        dret_div_cell #(.NUM_LIMBS(NL), .QBITS(CELL_QBITS)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl_in  (ch_ctl[g]),
            .div_in  (ch_div[g]),
            .num_in  (ch_num[g]),
            .rem_in  (ch_rem[g]),
            .ctl_out (ch_ctl[g+1]),
            .div_out (ch_div[g+1]),
            .num_out (ch_num[g+1]),
            .rem_out (ch_rem[g+1])
        );
    end

    dret_encode u_enc (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl_in (ch_ctl[NC]),
        .quo_in (256'(ch_num[NC])),
        .limit  (limit_reg),
        .done   (done),
        .bits   (next_bits)
    );
endmodule

// ===== hw/rtl/dret_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Port-level checks on the retarget block
module dret_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [31:0] next_bits,
    input logic        cfg_ready
);
    import dret_pkg::*;

    `CHK_IMPL(a_never_busy, clk, rst_n, 1'b1, !busy, "busy raised")
    `CHK_IMPL(a_cfg_ready, clk, rst_n, 1'b1, cfg_ready, "cfg not ready")
    `CHK_IMPL(a_done_cause, clk, rst_n, done, $past(start, PIPE_LAT), "done without start")
    `CHK_IMPL(a_start_done, clk, rst_n, $past(start, PIPE_LAT), done, "result dropped")
    `CHK_IMPL(a_bits_known, clk, rst_n, done, !$isunknown(next_bits), "next_bits unknown")
endmodule

bind difficulty_retarget dret_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .next_bits (next_bits),
    .cfg_ready (cfg_ready)
);

// ===== tb/difficulty_retarget_test.sv =====
`timescale 1ns / 1ps
module difficulty_retarget_test;
    import dret_pkg::*;

    localparam int LATENCY     = PIPE_LAT;
    localparam int WATCH_LIMIT = 2000;
    localparam int N_RANDOM    = 1500;

    // Directed row: expected is typed in only where fixed, else predicted
    typedef struct {
        logic [31:0] bits;
        logic [31:0] t_last;
        logic [31:0] t_first;
        bit          fixed;
        logic [31:0] want;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] prev_bits;
    logic [31:0] last_time;
    logic [31:0] first_time;
    logic        done;
    logic [31:0] next_bits;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [63:0] cfg_data;

    // Predictor copy of the registers
    logic [31:0]  span_goal;
    logic         hold_on;
    logic [255:0] easiest;

    logic [31:0] pending_bits[$];
    int          errors;
    int          idle_cycles;
    bit          quiet;
    row_t        rows[$];

    difficulty_retarget dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .prev_bits(prev_bits), .last_time(last_time), .first_time(first_time),
        .done(done), .next_bits(next_bits),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Compact form to 256-bit value, sign bit dropped
    function automatic logic [255:0] unpack_target(logic [31:0] bits);
        logic [7:0]   sz;
        logic [255:0] m;
        sz = bits[31:24];
        m  = {233'd0, bits[22:0]};
        if (sz <= 3)
            return m >> (8 * (3 - sz));
        if (sz >= 35)
            return '0;
        return m << (8 * (sz - 3));
    endfunction

    function automatic logic [31:0] pack_target(logic [255:0] v);
        int          nb;
        int          sz;
        logic [31:0] mant;
        logic [255:0] sh;
        nb = 0;
        for (int i = 255; i >= 0; i--)
        begin
            if (v[i])
            begin
                nb = i + 1;
                break;
            end
        end
        sz = (nb + 7) / 8;
        if (sz <= 3)
            sh = v << (8 * (3 - sz));
        else
            sh = v >> (8 * (sz - 3));
        mant = {8'd0, sh[23:0]};
        if (mant[23])
        begin
            mant = mant >> 8;
            sz++;
        end
        return mant | (32'(sz) << 24);
    endfunction

    function automatic logic [31:0] retarget(logic [31:0] bits, logic [31:0] t_last,
                                             logic [31:0] t_first);
        logic signed [63:0] span;
        logic signed [63:0] lo;
        logic signed [63:0] hi;
        logic [255:0] val;
        if (hold_on)
            return bits;
        span = $signed({32'd0, t_last}) - $signed({32'd0, t_first});
        lo   = {34'd0, span_goal[31:2]};
        hi   = {30'd0, span_goal, 2'b00};
        if (span < lo)
            span = lo;
        if (span > hi)
            span = hi;
        val = unpack_target(bits) * {192'd0, span};
        if (span_goal == 0)
            val = '1;
        else
            val = val / {224'd0, span_goal};
        if (val > easiest)
            val = easiest;
        return pack_target(val);
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_TIMESPAN: span_goal = data[31:0];
            REG_HOLD:     hold_on = data[0];
            REG_LIMIT0:   easiest[63:0] = data;
            REG_LIMIT1:   easiest[127:64] = data;
            REG_LIMIT2:   easiest[191:128] = data;
            REG_LIMIT3:   easiest[255:192] = data;
            default:      ;
        endcase
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_bits.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic set_setup(logic [31:0] goal, logic hold, logic [255:0] lim);
        drain_results();
        write_reg(REG_TIMESPAN, {32'd0, goal});
        write_reg(REG_HOLD, {63'd0, hold});
        write_reg(REG_LIMIT0, lim[63:0]);
        write_reg(REG_LIMIT1, lim[127:64]);
        write_reg(REG_LIMIT2, lim[191:128]);
        write_reg(REG_LIMIT3, lim[255:192]);
        cfg_valid <= 1'b0;
    endtask

    // Send one word; optional fixed expectation
    task automatic send_word(logic [31:0] b, logic [31:0] tl, logic [31:0] tf,
                             bit fixed, logic [31:0] want);
        logic [31:0] p;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        start      <= 1'b1;
        prev_bits  <= b;
        last_time  <= tl;
        first_time <= tf;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        p = retarget(b, tl, tf);
        if (fixed && p !== want)
        begin
            $display("%0t predictor disagrees with table: expected %h actual %h",
                     $time, want, p);
            errors++;
        end
        pending_bits.push_back(fixed ? want : p);
    endtask

    function automatic logic [31:0] rand_bits();
        logic [31:0] b;
        b = $urandom();
        if ($urandom_range(0, 3) != 0)
            b[31:24] = 8'($urandom_range(0, 36));
        return b;
    endfunction

    function automatic logic [31:0] rand_goal();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 7);
            1: return $urandom();
            2: return 32'hFFFF_FFFF;
            default: return $urandom_range(8, 5000000);
        endcase
    endfunction

    // Result checking
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_bits.size() == 0)
            begin
                $display("%0t unexpected result: expected none actual %h", $time, next_bits);
                errors++;
            end
            else
            begin
                if (next_bits !== pending_bits[0])
                begin
                    $display("%0t next_bits mismatch: expected %h actual %h",
                             $time, pending_bits[0], next_bits);
                    errors++;
                end
                void'(pending_bits.pop_front());
            end
        end
    end

    // Watchdog on cycles with no accepted word, configuration write or result
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCH_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] span_t;
        logic [31:0] t0;
        errors      = 0;
        quiet       = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        prev_bits   = '0;
        last_time   = '0;
        first_time  = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        span_goal   = 32'd1209600;
        hold_on     = 1'b0;
        easiest     = {32'd0, 32'hFFFF_FFFF, {192{1'b1}}};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table under reset settings
        rows = '{
            '{32'h1d00ffff, 32'd1209600, 32'd0, 1, 32'h1d00ffff},
            '{32'h1d00ffff, 32'd0, 32'd0, 1, 32'h1c3fffc0},
            '{32'h1d00ffff, 32'd0, 32'd1000, 0, 32'd0},
            '{32'h1d00ffff, 32'hFFFF_FFFF, 32'd0, 1, 32'h1d00ffff},
            '{32'h1b0404cb, 32'd1500000, 32'd300000, 0, 32'd0},
            '{32'h00000000, 32'd5, 32'd1, 1, 32'd0},
            '{32'h01123456, 32'd1209600, 32'd0, 1, 32'h01120000},
            '{32'h02ffffff, 32'd1209600, 32'd0, 0, 32'd0},
            '{32'h03800001, 32'd1209600, 32'd0, 1, 32'h01010000},
            '{32'hFF7FFFFF, 32'd1209600, 32'd0, 1, 32'd0},
            '{32'h207fffff, 32'd1209600, 32'd0, 1, 32'h1d00ffff},
            '{32'h21007fff, 32'd1209600, 32'd0, 0, 32'd0},
            '{32'h1c7fffff, 32'd4838400, 32'd0, 0, 32'd0},
            '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 32'd0}
        };
        foreach (rows[i])
            send_word(rows[i].bits, rows[i].t_last, rows[i].t_first, rows[i].fixed,
                      rows[i].want);

        // Hold mode passes bits through, sign included
        set_setup(32'd1209600, 1'b1, '1);
        send_word(32'hFFFF_FFFF, 32'd0, 32'd9, 1, 32'hFFFF_FFFF);
        send_word(32'h1d80ffff, 32'd9, 32'd0, 1, 32'h1d80ffff);
        // Zero divisor gives the limit; sub-four span gives zero
        set_setup(32'd0, 1'b0, '1);
        send_word(32'h1d00ffff, 32'd7, 32'd3, 1, 32'h2100ffff);
        set_setup(32'd3, 1'b0, {32'd0, 32'hFFFF_FFFF, {192{1'b1}}});
        send_word(32'h1d00ffff, 32'd5, 32'd5, 1, 32'd0);
        set_setup(32'hFFFF_FFFF, 1'b0, '0);
        send_word(32'h1d00ffff, 32'hFFFF_FFFF, 32'd0, 1, 32'd0);

        // Random phases with fresh settings
        for (int ph = 0; ph < 15; ph++)
        begin
            set_setup(rand_goal(), ($urandom_range(0, 7) == 0),
                      ($urandom_range(0, 2) == 0) ? 256'({$urandom(), $urandom(),
                       $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                       $urandom()}) >> $urandom_range(0, 255) : '1);
            quiet = (ph >= 13);
            for (int k = 0; k < N_RANDOM / 15; k++)
            begin
                t0 = $urandom();
                case ($urandom_range(0, 3))
                    0: span_t = $urandom();
                    1: span_t = span_goal >> $urandom_range(0, 4);
                    default: span_t = $urandom_range(0, 8000000);
                endcase
                send_word(rand_bits(), t0 + span_t, t0, 0, 32'd0);
            end
        end

        drain_results();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
